// ----- hw/rtl/rgb_light_pattern_engine_core_defines.svh -----
// rgb_light_pattern_engine_core_defines.svh
// Assertion macros for the light pattern engine RTL. No dependencies.
// Expects signals named clock and reset in the including module.
`ifndef RGB_LIGHT_PATTERN_ENGINE_CORE_DEFINES_SVH
`define RGB_LIGHT_PATTERN_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RLPE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define RLPE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/rlpe_pkg.sv -----
// rlpe_pkg.sv
// Types, mode codes, reset values and color helpers for the light pattern engine.
// No dependencies.
package rlpe_pkg;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;
      logic       tick_inc;
      logic       div_start;
      logic       tick_apply;
      logic       cmd_apply;
      logic       wr_en;
      logic       rd_en;
      logic       rd_cap;
      logic       play_adv;
      logic [1:0] byte_sel;
      logic [1:0] cap_sel;
      logic       publish;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic addr_match;
      logic slot_cmd;
      logic div_done;
      logic play_start;
   } dp_sts_type;

   // mode codes
   localparam logic [7:0] MODE_RGB_BLINK    = 8'd1;
   localparam logic [7:0] MODE_ONOFF_BLINK  = 8'd3;
   localparam logic [7:0] MODE_FADE_MIN     = 8'd4;
   localparam logic [7:0] MODE_RGB_FADE     = 8'd5;
   localparam logic [7:0] MODE_ONOFF_FADE   = 8'd7;
   localparam logic [7:0] MODE_TARGET_END   = 8'd8;
   localparam logic [7:0] MODE_ANIM_START   = 8'd63;
   localparam logic [7:0] MODE_SLOT_FIRST   = 8'd64;
   localparam logic [7:0] MODE_SLOT_END     = 8'd127;
   localparam logic [7:0] MODE_SAVE_MIN     = 8'd240;
   localparam logic [7:0] MODE_SET_ADDR     = 8'd241;

   localparam logic [7:0] BCAST_ADDR        = 8'hFF;
   localparam logic [7:0] FULL_DUTY         = 8'd255;
   localparam logic [7:0] ANIM_TICK_MASK    = 8'd63;
   localparam logic [7:0] SET_ADDR_SPEED    = 8'd64;

   // reset values
   localparam rgb_type    RST_COLOR         = '{r: 8'd255, g: 8'd255, b: 8'd0};
   localparam rgb_type    SET_ADDR_COLOR    = '{r: 8'd0, g: 8'd255, b: 8'd0};
   localparam logic [7:0] RST_MODE          = 8'd1;
   localparam logic [7:0] RST_FADE          = 8'd32;
   localparam logic [7:0] RST_UNIT_HI       = 8'd0;
   localparam logic [7:0] RST_UNIT_LO       = 8'd1;
   localparam logic [7:0] RST_BUS_ADDR      = 8'h11;

   // one count toward the target
   function automatic logic [7:0] approach(input logic [7:0] cur, input logic [7:0] tgt);
      logic [7:0] res;
      res = cur;
      if (cur > tgt) begin
         res = cur - 8'd1;
      end else if (cur < tgt) begin
         res = cur + 8'd1;
      end
      return res;
   endfunction

   // next color of the red -> yellow -> green -> cyan -> blue -> magenta wheel
   function automatic rgb_type rgb_cycle(input rgb_type c);
      rgb_type res;
      res = c;
      priority if (c.b == 8'd0 && c.r != 8'd0 && c.g == 8'd0) begin
         res.g = FULL_DUTY;
      end else if (c.r != 8'd0 && c.g != 8'd0) begin
         res.r = 8'd0;
      end else if (c.g != 8'd0 && c.b == 8'd0) begin
         res.b = FULL_DUTY;
      end else if (c.g != 8'd0 && c.b != 8'd0) begin
         res.g = 8'd0;
      end else if (c.b != 8'd0 && c.r == 8'd0) begin
         res.r = FULL_DUTY;
      end else if (c.b != 8'd0 && c.r != 8'd0) begin
         res.b = 8'd0;
      end else begin
         res.r = FULL_DUTY;
      end
      return res;
   endfunction

   // toggle between the saved color and dark
   function automatic rgb_type on_off(input rgb_type c, input rgb_type saved);
      rgb_type res;
      if (c == saved) begin
         res = '0;
      end else begin
         res = saved;
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/rlpe_ram.sv -----
// rlpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rlpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/rlpe_div.sv -----
// rlpe_div.sv
// Bit-serial 8-bit remainder unit, one restoring step per cycle.
// No dependencies. A zero divisor yields the dividend as remainder.
module rlpe_div (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] dividend,
   input  logic [7:0] divisor,
   output logic       done,
   output logic [7:0] rem
);

   logic [3:0] cnt_ff, cnt_in;
   logic [7:0] sh_ff, sh_in;
   logic [7:0] rem_ff, rem_in;
   logic [7:0] dvs_ff, dvs_in;
   logic [8:0] trial;

   always_comb begin
      cnt_in = cnt_ff;
      sh_in  = sh_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      trial  = {rem_ff, sh_ff[7]};
      if (start) begin
         cnt_in = 4'd8;
         sh_in  = dividend;
         rem_in = 8'd0;
         dvs_in = divisor;
      end else if (cnt_ff != 4'd0) begin
         cnt_in = cnt_ff - 4'd1;
         sh_in  = {sh_ff[6:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 8'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = (cnt_ff == 4'd0);
   assign rem  = rem_ff;

endmodule

// ----- hw/rtl/rlpe_dp.sv -----
// rlpe_dp.sv
// Datapath: engine state, command decode, pattern logic, slot store.
// Depends on rlpe_pkg, rlpe_div and rlpe_ram.
module rlpe_dp #(
   parameter int SEQ_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rlpe_pkg::ctrl_cmd_type cmd,
   output rlpe_pkg::dp_sts_type  sts,
   input  logic [7:0]            req_cmd_mode,
   input  logic [7:0]            req_cmd_speed,
   input  logic [7:0]            req_cmd_red,
   input  logic [7:0]            req_cmd_green,
   input  logic [7:0]            req_cmd_blue,
   input  logic [7:0]            req_cmd_addr_hi,
   input  logic [7:0]            req_cmd_addr_lo,
   output logic [7:0]            rsp_red_duty,
   output logic [7:0]            rsp_green_duty,
   output logic [7:0]            rsp_blue_duty,
   output logic [7:0]            rsp_mode_out,
   output logic [7:0]            rsp_bus_address_out
);

   localparam int AW   = $clog2(SEQ_DEPTH);
   localparam int ROWS = SEQ_DEPTH / 4;
   localparam int RW   = $clog2(ROWS);

   // captured transaction
   logic [7:0] c_mode_ff, c_speed_ff, c_addr_hi_ff, c_addr_lo_ff;
   rlpe_pkg::rgb_type c_rgb_ff;

   // engine state
   rlpe_pkg::rgb_type level_ff, level_in;
   rlpe_pkg::rgb_type target_ff, target_in;
   rlpe_pkg::rgb_type saved_ff, saved_in;
   logic [7:0]  mode_ff, mode_in;
   logic [7:0]  fade_ff, fade_in;
   logic [7:0]  tick_ff, tick_in;
   logic [15:0] anim_ff, anim_in;
   logic [7:0]  last_ff, last_in;
   logic [7:0]  unit_hi_ff, unit_hi_in;
   logic [7:0]  unit_lo_ff, unit_lo_in;
   logic [7:0]  bus_ff, bus_in;

   logic [ROWS-1:0] row_valid_ff;
   logic            rd_ok_ff;

   logic [7:0] tick_next;
   logic       div_done;
   logic [7:0] div_rem;
   logic       pat_hit;
   logic [7:0] eff_mode;
   logic [7:0] mode_tmp;
   logic [5:0] play_slot;
   logic [5:0] wr_slot;
   logic [7:0] wr_byte;
   logic [7:0] ram_q;
   logic [7:0] rd_byte;

   assign tick_next = tick_ff + 8'd1;
   assign pat_hit   = (anim_ff == {6'd0, fade_ff, 2'b00});
   assign eff_mode  = (mode_ff == rlpe_pkg::MODE_ANIM_START) ? rlpe_pkg::MODE_SLOT_FIRST
                                                             : mode_ff;
   // slot modes 64..126 map to slots 0..62 through the low bits
   assign play_slot = mode_ff[5:0];
   assign wr_slot   = c_mode_ff[5:0];
   assign rd_byte   = rd_ok_ff ? ram_q : 8'd0;

   always_comb begin
      unique case (cmd.byte_sel)
         2'd0:    wr_byte = c_speed_ff;
         2'd1:    wr_byte = c_rgb_ff.r;
         2'd2:    wr_byte = c_rgb_ff.g;
         default: wr_byte = c_rgb_ff.b;
      endcase
   end

   assign sts.addr_match = (c_addr_hi_ff == unit_hi_ff && c_addr_lo_ff == unit_lo_ff) ||
                           (c_addr_hi_ff == rlpe_pkg::BCAST_ADDR &&
                            c_addr_lo_ff == rlpe_pkg::BCAST_ADDR);
   assign sts.slot_cmd   = (c_mode_ff >= rlpe_pkg::MODE_SLOT_FIRST) &&
                           (c_mode_ff < rlpe_pkg::MODE_SLOT_END);
   assign sts.div_done   = div_done;
   assign sts.play_start = pat_hit && (eff_mode >= rlpe_pkg::MODE_SLOT_FIRST) &&
                           (eff_mode < rlpe_pkg::MODE_SLOT_END);

   rlpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (tick_next),
      .divisor  (fade_ff),
      .done     (div_done),
      .rem      (div_rem)
   );

   rlpe_ram #(
      .WIDTH (8),
      .DEPTH (SEQ_DEPTH)
   ) u_seq_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (AW'({wr_slot, cmd.byte_sel})),
      .wr_data (wr_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (AW'({play_slot, cmd.byte_sel})),
      .rd_data (ram_q)
   );

   always_comb begin
      level_in   = level_ff;
      target_in  = target_ff;
      saved_in   = saved_ff;
      mode_in    = mode_ff;
      fade_in    = fade_ff;
      tick_in    = tick_ff;
      anim_in    = anim_ff;
      last_in    = last_ff;
      unit_hi_in = unit_hi_ff;
      unit_lo_in = unit_lo_ff;
      bus_in     = bus_ff;
      mode_tmp   = mode_ff;

      if (cmd.tick_inc) begin
         tick_in = tick_next;
         if ((tick_next & rlpe_pkg::ANIM_TICK_MASK) == 8'd0) begin
            anim_in = anim_ff + 16'd1;
         end
      end

      // fade step, then the pattern action on a pattern period
      if (cmd.tick_apply) begin
         if (div_rem == 8'd0 && mode_ff >= rlpe_pkg::MODE_FADE_MIN) begin
            level_in.r = rlpe_pkg::approach(level_ff.r, target_ff.r);
            level_in.g = rlpe_pkg::approach(level_ff.g, target_ff.g);
            level_in.b = rlpe_pkg::approach(level_ff.b, target_ff.b);
         end
         if (pat_hit) begin
            anim_in = 16'd0;
            unique case (mode_ff)
               rlpe_pkg::MODE_RGB_BLINK:   level_in  = rlpe_pkg::rgb_cycle(level_ff);
               rlpe_pkg::MODE_ONOFF_BLINK: level_in  = rlpe_pkg::on_off(level_ff, saved_ff);
               rlpe_pkg::MODE_RGB_FADE:    target_in = rlpe_pkg::rgb_cycle(target_ff);
               rlpe_pkg::MODE_ONOFF_FADE:  target_in = rlpe_pkg::on_off(target_ff, saved_ff);
               default:                    mode_in   = eff_mode;
            endcase
         end
      end

      // slot playback: speed then red, green, blue
      if (cmd.rd_cap) begin
         unique case (cmd.cap_sel)
            2'd0:    fade_in     = rd_byte;
            2'd1:    target_in.r = rd_byte;
            2'd2:    target_in.g = rd_byte;
            default: target_in.b = rd_byte;
         endcase
      end
      if (cmd.play_adv) begin
         mode_in = (mode_ff >= last_ff) ? rlpe_pkg::MODE_SLOT_FIRST : mode_ff + 8'd1;
      end

      if (cmd.cmd_apply && sts.addr_match) begin
         tick_in = 8'd0;
         anim_in = 16'd0;
         if (c_mode_ff < rlpe_pkg::MODE_FADE_MIN) begin
            level_in = c_rgb_ff;
            saved_in = c_rgb_ff;
         end else if (c_mode_ff < rlpe_pkg::MODE_TARGET_END) begin
            target_in = c_rgb_ff;
            saved_in  = c_rgb_ff;
         end else if (c_mode_ff == rlpe_pkg::MODE_SET_ADDR) begin
            unit_hi_in = c_rgb_ff.r;
            unit_lo_in = c_rgb_ff.g;
            bus_in     = c_rgb_ff.b;
            mode_tmp   = rlpe_pkg::MODE_RGB_FADE;
            fade_in    = rlpe_pkg::SET_ADDR_SPEED;
            target_in  = rlpe_pkg::SET_ADDR_COLOR;
            saved_in   = rlpe_pkg::SET_ADDR_COLOR;
         end
         mode_in = mode_tmp;
         if (c_mode_ff <= rlpe_pkg::MODE_ANIM_START) begin
            mode_in = c_mode_ff;
            fade_in = c_speed_ff;
         end else if (c_mode_ff < rlpe_pkg::MODE_SLOT_END) begin
            last_in = c_mode_ff;
         end else if (c_mode_ff >= rlpe_pkg::MODE_SAVE_MIN) begin
            if (mode_tmp > rlpe_pkg::MODE_ANIM_START) begin
               mode_in = rlpe_pkg::MODE_ANIM_START;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= rlpe_pkg::RST_COLOR;
         target_ff    <= rlpe_pkg::RST_COLOR;
         saved_ff     <= rlpe_pkg::RST_COLOR;
         mode_ff      <= rlpe_pkg::RST_MODE;
         fade_ff      <= rlpe_pkg::RST_FADE;
         tick_ff      <= 8'd0;
         anim_ff      <= 16'd0;
         last_ff      <= 8'd0;
         unit_hi_ff   <= rlpe_pkg::RST_UNIT_HI;
         unit_lo_ff   <= rlpe_pkg::RST_UNIT_LO;
         bus_ff       <= rlpe_pkg::RST_BUS_ADDR;
         row_valid_ff <= '0;
      end else begin
         level_ff     <= level_in;
         target_ff    <= target_in;
         saved_ff     <= saved_in;
         mode_ff      <= mode_in;
         fade_ff      <= fade_in;
         tick_ff      <= tick_in;
         anim_ff      <= anim_in;
         last_ff      <= last_in;
         unit_hi_ff   <= unit_hi_in;
         unit_lo_ff   <= unit_lo_in;
         bus_ff       <= bus_in;
         if (cmd.wr_en) begin
            row_valid_ff[RW'(wr_slot)] <= 1'b1;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         c_mode_ff    <= req_cmd_mode;
         c_speed_ff   <= req_cmd_speed;
         c_rgb_ff     <= '{r: req_cmd_red, g: req_cmd_green, b: req_cmd_blue};
         c_addr_hi_ff <= req_cmd_addr_hi;
         c_addr_lo_ff <= req_cmd_addr_lo;
      end
      if (cmd.rd_en) begin
         rd_ok_ff <= row_valid_ff[RW'(play_slot)];
      end
      if (cmd.publish) begin
         rsp_red_duty        <= level_ff.r;
         rsp_green_duty      <= level_ff.g;
         rsp_blue_duty       <= level_ff.b;
         rsp_mode_out        <= mode_ff;
         rsp_bus_address_out <= bus_ff;
      end
   end

endmodule

// ----- hw/rtl/rlpe_ctrl.sv -----
// rlpe_ctrl.sv
// Controller state machine: sequences ticks, commands, slot reads and writes.
// Depends on rlpe_pkg and rgb_light_pattern_engine_core_defines.svh.
`include "rgb_light_pattern_engine_core_defines.svh"

module rlpe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rlpe_pkg::ctrl_cmd_type cmd,
   input  rlpe_pkg::dp_sts_type   sts
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TICK  = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_APPLY = 3'd3;
   localparam logic [2:0] S_RD    = 3'd4;
   localparam logic [2:0] S_CMD   = 3'd5;
   localparam logic [2:0] S_WR    = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   localparam logic [2:0] WR_LAST = 3'd3;
   localparam logic [2:0] RD_LAST = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      req_ready    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = req_func ? S_CMD : S_TICK;
            end
         end
         S_TICK: begin
            cmd.tick_inc  = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.tick_apply = 1'b1;
            cnt_in         = 3'd0;
            state_in       = sts.play_start ? S_RD : S_DONE;
         end
         S_RD: begin
            // each read is captured in the cycle after it is issued
            cmd.rd_en    = (cnt_ff != RD_LAST);
            cmd.byte_sel = cnt_ff[1:0];
            cmd.rd_cap   = (cnt_ff != 3'd0);
            cmd.cap_sel  = 2'(cnt_ff - 3'd1);
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == RD_LAST) begin
               cmd.play_adv = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_CMD: begin
            cmd.cmd_apply = 1'b1;
            cnt_in        = 3'd0;
            state_in      = (sts.addr_match && sts.slot_cmd) ? S_WR : S_DONE;
         end
         S_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.byte_sel = cnt_ff[1:0];
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == WR_LAST) begin
               state_in = S_DONE;
            end
         end
         default: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RLPE_ASSERT_SAME(a_wr_cnt_range, state_ff == S_WR, cnt_ff <= WR_LAST, "slot write count out of range")
   `RLPE_ASSERT_NEXT(a_div_exit, (state_ff == S_DIV) && sts.div_done, state_ff == S_APPLY, "remainder done but no fade step")
   `RLPE_ASSERT_NEXT(a_done_hold, (state_ff == S_DONE) && rsp_valid_ff && !rsp_ready, state_ff == S_DONE, "result published over an untaken one")

endmodule

// ----- hw/rtl/rgb_light_pattern_engine_core.sv -----
// RGB light pattern engine. Each request transaction is a timer tick (req_func = 0) or a
// decoded 7-byte command (req_func = 1); every request yields exactly one response
// transaction carrying the three PWM duties, the mode and the bus address as they stand
// after that request. For a tick, the fade test needs tick_count modulo the fade period,
// which a bit-serial remainder unit works out; on a pattern period in slot playback the
// tick then reads the four bytes of the slot from the sequence RAM, one read port. A
// command that stores an animation slot makes four RAM writes. One request is in work
// at a time; a finished response waits in its output register, so the next request is
// accepted while the previous response is still untaken. Speed 0 makes the remainder
// equal tick_count itself. Slot storage is cleared at reset through per-slot valid bits,
// so no clearing pass is needed and the block is ready straight out of reset.
// Depends on rlpe_pkg, rlpe_ctrl, rlpe_dp (with rlpe_div and rlpe_ram).
module rgb_light_pattern_engine_core #(
   parameter int SEQ_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_cmd_mode,
   input  logic [7:0] req_cmd_speed,
   input  logic [7:0] req_cmd_red,
   input  logic [7:0] req_cmd_green,
   input  logic [7:0] req_cmd_blue,
   input  logic [7:0] req_cmd_addr_hi,
   input  logic [7:0] req_cmd_addr_lo,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_red_duty,
   output logic [7:0] rsp_green_duty,
   output logic [7:0] rsp_blue_duty,
   output logic [7:0] rsp_mode_out,
   output logic [7:0] rsp_bus_address_out
);

   rlpe_pkg::ctrl_cmd_type cmd;
   rlpe_pkg::dp_sts_type   sts;

   // sequencing: one state per phase of a tick or command
   rlpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // colors, counters, addresses, slot store and the response register
   rlpe_dp #(
      .SEQ_DEPTH (SEQ_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_cmd_mode        (req_cmd_mode),
      .req_cmd_speed       (req_cmd_speed),
      .req_cmd_red         (req_cmd_red),
      .req_cmd_green       (req_cmd_green),
      .req_cmd_blue        (req_cmd_blue),
      .req_cmd_addr_hi     (req_cmd_addr_hi),
      .req_cmd_addr_lo     (req_cmd_addr_lo),
      .rsp_red_duty        (rsp_red_duty),
      .rsp_green_duty      (rsp_green_duty),
      .rsp_blue_duty       (rsp_blue_duty),
      .rsp_mode_out        (rsp_mode_out),
      .rsp_bus_address_out (rsp_bus_address_out)
   );

endmodule
